@@ design/rfms_pkg.sv @@
package rfms_pkg;

    // Field widths
    localparam int COORD_W   = 32;
    localparam int SIZE_W    = 31;
    localparam int UNIT_W    = 12;
    localparam int CFG_IDX_W = 1;

    // Entries with a unit id at or above this bound are skipped
    localparam int MAX_UNITS = 4096;

    // Root of a 62-bit radicand, one result bit per step
    localparam int SQRT_STEPS = 31;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SHAPE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SIZE  = 1'b1;

    // Reset value of the region size (1.0 in Q16.16)
    localparam logic [SIZE_W-1:0] SIZE_RESET = 31'd65536;

    typedef enum logic [1:0] {
        SHAPE_CIRCLE = 2'd0,
        SHAPE_SQUARE = 2'd1,
        SHAPE_HEART  = 2'd2,
        SHAPE_NONE   = 2'd3
    } t_shape;

    // Operand pair and destination of the shared multiplier
    typedef enum logic [2:0] {
        MUL_XX,
        MUL_YY,
        MUL_SS,
        MUL_XS,
        MUL_DL,
        MUL_DH
    } t_mul_sel;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sqrt_step;
        logic     diff_en;
        logic     sum_en;
        logic     cmp_en;
        logic     out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_shape shape;
        logic   last;
    } t_stat;

endpackage

@@ design/rfms_datapath.sv @@
module rfms_datapath #(
    parameter int MAX_UNITS = rfms_pkg::MAX_UNITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rfms_pkg::t_cmd                  i_cmd,
    output rfms_pkg::t_stat                 o_stat,
    input  logic                            i_dangling_valid,
    input  logic [rfms_pkg::COORD_W-1:0]    i_point_x,
    input  logic [rfms_pkg::COORD_W-1:0]    i_point_y,
    input  logic [rfms_pkg::UNIT_W-1:0]     i_entry_unit,
    input  logic                            i_last_entry,
    input  logic                            i_cfg_we,
    input  logic [rfms_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfms_pkg::SIZE_W-1:0]     i_cfg_data,
    output logic                            o_found,
    output logic [rfms_pkg::UNIT_W-1:0]     o_chosen_unit
);
    import rfms_pkg::*;

    // Configuration
    t_shape              r_shape;
    logic [SIZE_W-1:0]   r_size;

    // Captured entry
    logic                r_dvalid;
    logic [COORD_W-1:0]  r_x;
    logic [COORD_W-1:0]  r_y;
    logic [UNIT_W-1:0]   r_unit_in;
    logic                r_last;

    // Products and intermediate terms
    logic [63:0]         r_pxx;
    logic [63:0]         r_pyy;
    logic [63:0]         r_pss;
    logic [61:0]         r_rad;
    logic [32:0]         r_rem;
    logic [30:0]         r_root;
    logic [31:0]         r_dl;
    logic [2:0]          r_dh;
    logic [63:0]         r_rest;
    logic [63:0]         r_pdl;
    logic [34:0]         r_pdh;
    logic [70:0]         r_lhs;

    // Match state of the current list
    logic                r_seen;
    logic [UNIT_W-1:0]   r_unit;

    logic [31:0]         w_ax;
    logic [31:0]         w_ay;
    logic [31:0]         w_mul_a;
    logic [31:0]         w_mul_b;
    logic [63:0]         w_prod;
    logic [34:0]         w_rem_sh;
    logic [34:0]         w_trial;
    logic [34:0]         w_rem_sub;
    logic [35:0]         w_y_ext;
    logic [35:0]         w_dd;
    logic [35:0]         w_d;
    logic [5:0]          w_dhsq;
    logic [64:0]         w_sum_xy;
    logic [70:0]         w_rhs;
    logic                w_ax_in;
    logic                w_ay_in;
    logic                w_hit;
    logic                w_take;
    logic                n_seen;
    logic [UNIT_W-1:0]   n_unit;

    assign o_stat.shape = r_shape;
    assign o_stat.last  = r_last;

    // Magnitudes; the most negative code maps to 2^31, which fits in 32 bits
    assign w_ax = r_x[COORD_W-1] ? (32'd0 - r_x) : r_x;
    assign w_ay = r_y[COORD_W-1] ? (32'd0 - r_y) : r_y;

    // Shared 32x32 unsigned multiplier
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_XX: begin
                w_mul_a = w_ax;
                w_mul_b = w_ax;
            end
            MUL_YY: begin
                w_mul_a = w_ay;
                w_mul_b = w_ay;
            end
            MUL_SS: begin
                w_mul_a = {1'b0, r_size};
                w_mul_b = {1'b0, r_size};
            end
            MUL_XS: begin
                w_mul_a = w_ax;
                w_mul_b = {1'b0, r_size};
            end
            MUL_DL: begin
                w_mul_a = r_dl;
                w_mul_b = r_dl;
            end
            MUL_DH: begin
                w_mul_a = r_dl;
                w_mul_b = {29'd0, r_dh};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end
    assign w_prod = w_mul_a * w_mul_b;

    // One step of the digit-by-digit square root
    assign w_rem_sh  = {r_rem, r_rad[61:60]};
    assign w_trial   = {2'b00, r_root, 2'b01};
    assign w_rem_sub = w_rem_sh - w_trial;

    // D = 5*Y - 4*R, then |D| split into low 32 bits and high 3 bits
    assign w_y_ext = {{4{r_y[COORD_W-1]}}, r_y};
    assign w_dd    = (w_y_ext << 2) + w_y_ext - {3'b000, r_root, 2'b00};
    assign w_d     = w_dd[35] ? (36'd0 - w_dd) : w_dd;
    assign w_dhsq  = {3'b000, r_dh} * {3'b000, r_dh};

    // Region tests
    assign w_ax_in  = w_ax < {1'b0, r_size};
    assign w_ay_in  = w_ay < {1'b0, r_size};
    assign w_sum_xy = {1'b0, r_pxx} + {1'b0, r_pyy};
    assign w_rhs    = {3'b000, r_rest, 4'b0000};

    always_comb begin
        unique case (r_shape)
            SHAPE_CIRCLE: w_hit = w_sum_xy < {1'b0, r_pss};
            SHAPE_SQUARE: w_hit = w_ax_in && w_ay_in;
            SHAPE_HEART:  w_hit = w_ax_in && (r_lhs < w_rhs);
            SHAPE_NONE:   w_hit = 1'b0;
            default:      w_hit = 1'b0;
        endcase
    end

    // First match wins; later entries of the list are ignored
    assign w_take = !r_seen && r_dvalid && (32'(r_unit_in) < 32'(MAX_UNITS)) && w_hit;
    assign n_seen = r_seen | w_take;
    assign n_unit = w_take ? r_unit_in : r_unit;

    // Configuration registers and match state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape <= SHAPE_CIRCLE;
            r_size  <= SIZE_RESET;
            r_seen  <= 1'b0;
            r_unit  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_IDX_SHAPE: r_shape <= t_shape'(i_cfg_data[1:0]);
                    CFG_IDX_SIZE:  r_size  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.cmp_en) begin
                if (i_cmd.out_load) begin
                    r_seen <= 1'b0;
                    r_unit <= '0;
                end else begin
                    r_seen <= n_seen;
                    r_unit <= n_unit;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dvalid  <= i_dangling_valid;
            r_x       <= i_point_x;
            r_y       <= i_point_y;
            r_unit_in <= i_entry_unit;
            r_last    <= i_last_entry;
        end
        if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_sel)
                MUL_XX: r_pxx <= w_prod;
                MUL_YY: r_pyy <= w_prod;
                MUL_SS: r_pss <= w_prod;
                MUL_XS: begin
                    // when ax < s the product fits in 62 bits; otherwise the heart test fails on ax
                    r_rad  <= w_prod[61:0];
                    r_rem  <= '0;
                    r_root <= '0;
                end
                MUL_DL: r_pdl <= w_prod;
                MUL_DH: r_pdh <= w_prod[34:0];
                default: ;
            endcase
        end
        if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[59:0], 2'b00};
            if (w_rem_sh >= w_trial) begin
                r_rem  <= w_rem_sub[32:0];
                r_root <= {r_root[29:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh[32:0];
                r_root <= {r_root[29:0], 1'b0};
            end
        end
        if (i_cmd.diff_en) begin
            r_dl   <= w_d[31:0];
            r_dh   <= w_d[34:32];
            r_rest <= r_pss - r_pxx;
        end
        if (i_cmd.sum_en) begin
            r_lhs <= {7'd0, r_pdl} + {3'b000, r_pdh, 33'd0} + {1'b0, w_dhsq, 64'd0};
        end
        if (i_cmd.out_load) begin
            o_found       <= n_seen;
            o_chosen_unit <= n_unit;
        end
    end

endmodule

@@ design/rfms_ctrl.sv @@
module rfms_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  rfms_pkg::t_stat i_stat,
    output rfms_pkg::t_cmd  o_cmd
);
    import rfms_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_XX,
        S_MUL_YY,
        S_MUL_SS,
        S_MUL_XS,
        S_SQRT,
        S_DIFF,
        S_MUL_DL,
        S_MUL_DH,
        S_SUM,
        S_CMP
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [SQRT_CNT_W-1:0]  r_cnt;
    logic                   r_out_valid;
    logic                   w_out_free;
    logic                   w_accept;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Command decode and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = w_accept;
                if (w_accept) begin
                    unique case (i_stat.shape)
                        SHAPE_CIRCLE, SHAPE_HEART: n_state = S_MUL_XX;
                        default:                   n_state = S_CMP;
                    endcase
                end
            end
            S_MUL_XX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_XX;
                n_state       = S_MUL_SS;
            end
            S_MUL_SS: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SS;
                n_state       = (i_stat.shape == SHAPE_HEART) ? S_MUL_XS : S_MUL_YY;
            end
            S_MUL_YY: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_YY;
                n_state       = S_CMP;
            end
            S_MUL_XS: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_XS;
                n_state       = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff_en = 1'b1;
                n_state       = S_MUL_DL;
            end
            S_MUL_DL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DL;
                n_state       = S_MUL_DH;
            end
            S_MUL_DH: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DH;
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = S_CMP;
            end
            S_CMP: begin
                // a closing entry waits here until the output register is free
                if (!i_stat.last || w_out_free) begin
                    o_cmd.cmp_en   = 1'b1;
                    o_cmd.out_load = i_stat.last;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SQRT) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ design/region_first_match_scan_unit.sv @@
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------------
// in       | input     | i_in_valid / o_in_stall  | dangling_valid, point_x/y, entry_unit, last
// out      | output    | o_out_valid / i_out_stall| found, chosen_unit
// cfg      | input     | i_cfg_valid / o_cfg_ready| cfg_index, cfg_data
//
// Square and none go straight to compare; heart adds a bit-serial square root;
// the shared 32x32 multiplier serializes the products.
// A result lands in an output register; the next entry is taken while it waits.
// A closing entry holds in its compare step while the output register is full.
// Reset is synchronous, active low; shape returns to circle and size to 1.0.
module region_first_match_scan_unit #(
    parameter int MAX_UNITS = rfms_pkg::MAX_UNITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_dangling_valid,
    input  logic [rfms_pkg::COORD_W-1:0]    i_point_x,
    input  logic [rfms_pkg::COORD_W-1:0]    i_point_y,
    input  logic [rfms_pkg::UNIT_W-1:0]     i_entry_unit,
    input  logic                            i_last_entry,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_found,
    output logic [rfms_pkg::UNIT_W-1:0]     o_chosen_unit,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rfms_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfms_pkg::SIZE_W-1:0]     i_cfg_data
);
    import rfms_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_cfg_we;

    // Register writes are taken in any cycle
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    rfms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    rfms_datapath #(
        .MAX_UNITS (MAX_UNITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_dangling_valid (i_dangling_valid),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_entry_unit     (i_entry_unit),
        .i_last_entry     (i_last_entry),
        .i_cfg_we         (w_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_found          (o_found),
        .o_chosen_unit    (o_chosen_unit)
    );

endmodule

@@ tb/tb_region_first_match_scan_unit.sv @@
module tb_region_first_match_scan_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rfms_pkg::*;

    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ENTRIES  = 50;
    localparam int MAX_REPORTS    = 10;

    localparam logic [COORD_W-1:0] Q_ONE   = 32'h0001_0000;
    localparam logic [COORD_W-1:0] Q_HALF  = 32'h0000_8000;
    localparam logic [COORD_W-1:0] C_MIN   = 32'h8000_0000;
    localparam logic [COORD_W-1:0] C_MAX   = 32'h7FFF_FFFF;
    localparam logic [SIZE_W-1:0]  S_MAX   = 31'h7FFF_FFFF;
    localparam logic [SIZE_W-1:0]  S_ZERO  = 31'd0;

    // One boundary entry as seen on the input channel
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [UNIT_W-1:0]  unit;
        logic               last;
    } t_entry;

    // One scan outcome as seen on the output channel
    typedef struct packed {
        logic              found;
        logic [UNIT_W-1:0] unit;
    } t_verdict;

    typedef enum int {
        STALL_OFF,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    // Tracks the region config and the first-match scan, queues expected verdicts
    class first_match_board;
        t_shape            shape;
        logic [SIZE_W-1:0] size;
        logic              held;
        logic [UNIT_W-1:0] held_unit;
        t_verdict          due_verdicts[$];
        int                errors;

        function new();
            shape     = SHAPE_CIRCLE;
            size      = SIZE_RESET;
            held      = 1'b0;
            held_unit = '0;
            errors    = 0;
        endfunction

        function void flag(input string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        // floor(sqrt(v)), bit by bit from the top
        function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
            logic [31:0] root;
            logic [63:0] trial;
            int b;
            root = '0;
            for (b = 31; b >= 0; b--) begin
                trial = {32'b0, root | (32'd1 << b)};
                if (trial * trial <= v)
                    root = root | (32'd1 << b);
            end
            return root;
        endfunction

        // Strict inside test on raw Q16.16 codes, wide enough that nothing overflows
        function automatic bit point_inside(input logic [COORD_W-1:0] x,
                                            input logic [COORD_W-1:0] y);
            logic signed [127:0] xw;
            logic signed [127:0] yw;
            logic signed [127:0] dev;
            logic [127:0] ax;
            logic [127:0] ay;
            logic [127:0] sw;
            logic [127:0] prod;
            logic [127:0] root;
            logic [127:0] adev;
            xw = {{96{x[31]}}, x};
            yw = {{96{y[31]}}, y};
            ax = (xw < 0) ? -xw : xw;
            ay = (yw < 0) ? -yw : yw;
            sw = {97'b0, size};
            case (shape)
                SHAPE_CIRCLE: return (ax * ax + ay * ay) < (sw * sw);
                SHAPE_SQUARE: return (ax < sw) && (ay < sw);
                SHAPE_HEART: begin
                    if (ax >= sw)
                        return 1'b0;
                    prod = ax * sw;
                    root = {96'b0, floor_sqrt(prod[63:0])};
                    // four times the code of 1.25*y - sqrt(|x|*s)
                    dev  = 5 * yw - 4 * $signed(root);
                    adev = (dev < 0) ? -dev : dev;
                    return (adev * adev) < ((sw * sw - ax * ax) << 4);
                end
                default: return 1'b0;
            endcase
        endfunction

        function void note_config(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [SIZE_W-1:0] data);
            if (idx == CFG_IDX_SHAPE)
                shape = t_shape'(data[1:0]);
            else if (idx == CFG_IDX_SIZE)
                size = data;
        endfunction

        function void note_entry(input t_entry e);
            t_verdict v;
            if (!held && e.valid && (e.unit < MAX_UNITS) && point_inside(e.x, e.y)) begin
                held      = 1'b1;
                held_unit = e.unit;
            end
            if (e.last) begin
                v.found = held;
                v.unit  = held ? held_unit : '0;
                due_verdicts = {due_verdicts, v};
                held      = 1'b0;
                held_unit = '0;
            end
        endfunction

        function void check_result(input logic found, input logic [UNIT_W-1:0] unit);
            t_verdict v;
            if (due_verdicts.size() == 0) begin
                flag($sformatf("unexpected result: found=%0b unit=%0d", found, unit));
                return;
            end
            v = due_verdicts.pop_front();
            if (found !== v.found || unit !== v.unit)
                flag($sformatf("result mismatch: expected found=%0b unit=%0d, got found=%0b unit=%0d",
                               v.found, v.unit, found, unit));
        endfunction

        function int verdicts_due();
            return due_verdicts.size();
        endfunction

        function void finish_check();
            if (due_verdicts.size() != 0)
                flag($sformatf("%0d expected results never arrived", due_verdicts.size()));
        endfunction
    endclass

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_in_valid       = 1'b0;
    logic                 o_in_stall;
    logic                 i_dangling_valid = 1'b0;
    logic [COORD_W-1:0]   i_point_x        = '0;
    logic [COORD_W-1:0]   i_point_y        = '0;
    logic [UNIT_W-1:0]    i_entry_unit     = '0;
    logic                 i_last_entry     = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall      = 1'b0;
    logic                 o_found;
    logic [UNIT_W-1:0]    o_chosen_unit;
    logic                 i_cfg_valid      = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index      = '0;
    logic [SIZE_W-1:0]    i_cfg_data       = '0;

    first_match_board board;
    int               burst_left   = 0;
    int               idle_cycles  = 0;
    t_stall_mode      stall_mode   = STALL_OFF;
    int               stall_left   = 0;
    int               stall_period = 2;
    int               stall_phase  = 0;

    region_first_match_scan_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_dangling_valid (i_dangling_valid),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_entry_unit     (i_entry_unit),
        .i_last_entry     (i_last_entry),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_found          (o_found),
        .o_chosen_unit    (o_chosen_unit),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver back-pressure: off, light, heavy or periodic, in randomly switching modes
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode   = t_stall_mode'($urandom_range(0, 3));
            stall_left   = $urandom_range(8, 120);
            stall_period = $urandom_range(2, 9);
        end
        stall_left  = stall_left - 1;
        stall_phase = stall_phase + 1;
        case (stall_mode)
            STALL_OFF:   i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= ((stall_phase % stall_period) < (stall_period / 2));
        endcase
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result(o_found, o_chosen_unit);
    end

    // Watchdog on cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                     || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_entry mk_entry(input logic valid, input logic [COORD_W-1:0] x,
                                        input logic [COORD_W-1:0] y,
                                        input logic [UNIT_W-1:0] unit, input logic last);
        t_entry e;
        e.valid = valid;
        e.x     = x;
        e.y     = y;
        e.unit  = unit;
        e.last  = last;
        return e;
    endfunction

    // Coordinate biased toward the region size and its edges
    function automatic logic [COORD_W-1:0] pick_coord(input logic [SIZE_W-1:0] s);
        longint v;
        longint span;
        span = longint'(s) + longint'(s) / 4 + 1;
        case ($urandom_range(0, 9))
            0, 1: v = longint'(int'($urandom));
            2: begin
                case ($urandom_range(0, 3))
                    0:       v = longint'(s);
                    1:       v = longint'(s) - 1;
                    2:       v = -longint'(s);
                    default: v = 1 - longint'(s);
                endcase
            end
            3: v = ($urandom_range(0, 1) != 0) ? 64'sd2147483647 : -64'sd2147483648;
            default: begin
                v = longint'($urandom_range(0, span[31:0]));
                if ($urandom_range(0, 1) != 0)
                    v = -v;
            end
        endcase
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // Input transfer, with bursts and random gaps between them
    task automatic send_entry(input t_entry e);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_dangling_valid <= e.valid;
        i_point_x        <= e.x;
        i_point_y        <= e.y;
        i_entry_unit     <= e.unit;
        i_last_entry     <= e.last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        board.note_entry(e);
        burst_left--;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        board.note_config(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop sending, wait out every expected result, then let the datapath settle
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.verdicts_due() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_region(input t_shape shape, input logic [SIZE_W-1:0] size);
        drain_results();
        write_reg(CFG_IDX_SHAPE, {{(SIZE_W-2){1'b0}}, shape});
        write_reg(CFG_IDX_SIZE, size);
    endtask

    // Random lists: mostly well-formed scans, some broken noise
    task automatic run_random_phase(input int n_entries);
        t_entry            e;
        t_shape            shape;
        logic [SIZE_W-1:0] size;
        int                sent;
        int                len;
        int                k;
        bit                noisy;
        shape = t_shape'($urandom_range(0, 3));
        case ($urandom_range(0, 5))
            0:       size = S_ZERO;
            1:       size = S_MAX;
            2:       size = SIZE_RESET;
            3:       size = SIZE_W'($urandom_range(1, 1 << 20));
            4:       size = SIZE_W'($urandom_range(1, 255));
            default: size = SIZE_W'($urandom);
        endcase
        set_region(shape, size);
        sent = 0;
        while (sent < n_entries) begin
            len   = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
            noisy = ($urandom_range(0, 9) == 0);
            for (k = 0; k < len; k++) begin
                if (noisy) begin
                    e.valid = ($urandom_range(0, 1) != 0);
                    e.x     = $urandom;
                    e.y     = $urandom;
                end else begin
                    e.valid = ($urandom_range(0, 7) != 0);
                    e.x     = pick_coord(size);
                    e.y     = pick_coord(size);
                end
                e.unit = UNIT_W'($urandom_range(0, 4095));
                e.last = (k == len - 1);
                send_entry(e);
                sent++;
            end
        end
    endtask

    initial begin
        int phase;
        board = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Reset region: circle of size 1.0
        send_entry(mk_entry(1'b1, '0, '0, 12'd5, 1'b1));
        send_entry(mk_entry(1'b0, '0, '0, 12'd6, 1'b1));
        // on-edge point misses, first inside point wins, later match ignored
        send_entry(mk_entry(1'b1, Q_ONE, '0, 12'd1, 1'b0));
        send_entry(mk_entry(1'b1, '0, -(Q_ONE - 1), 12'd2, 1'b0));
        send_entry(mk_entry(1'b1, '0, '0, 12'd3, 1'b0));
        send_entry(mk_entry(1'b1, C_MIN, C_MAX, 12'd4, 1'b1));
        send_entry(mk_entry(1'b1, C_MIN, C_MIN, 12'd4095, 1'b1));

        // Largest square: edges of the coordinate range
        set_region(SHAPE_SQUARE, S_MAX);
        send_entry(mk_entry(1'b1, C_MIN, '0, 12'd7, 1'b1));
        send_entry(mk_entry(1'b1, 32'h8000_0001, '0, 12'd8, 1'b1));
        send_entry(mk_entry(1'b1, 32'h8000_0002, 32'h7FFF_FFFE, 12'd4095, 1'b1));

        // Heart of size 1.0
        set_region(SHAPE_HEART, SIZE_RESET);
        send_entry(mk_entry(1'b1, '0, Q_HALF, 12'd9, 1'b1));
        send_entry(mk_entry(1'b1, '0, -32'sd58982, 12'd10, 1'b0));
        send_entry(mk_entry(1'b1, Q_HALF, 32'h0000_CCCD, 12'd11, 1'b1));
        send_entry(mk_entry(1'b1, Q_ONE, '0, 12'd12, 1'b1));

        // Largest heart
        set_region(SHAPE_HEART, S_MAX);
        send_entry(mk_entry(1'b1, C_MAX, '0, 12'd13, 1'b0));
        send_entry(mk_entry(1'b1, 32'h4000_0000, 32'h4000_0000, 12'd14, 1'b1));
        send_entry(mk_entry(1'b1, 32'hC000_0000, C_MIN, 12'd0, 1'b1));

        // Shape none never matches
        set_region(SHAPE_NONE, SIZE_RESET);
        send_entry(mk_entry(1'b1, '0, '0, 12'd15, 1'b1));

        // Zero size matches nothing
        set_region(SHAPE_CIRCLE, S_ZERO);
        send_entry(mk_entry(1'b1, '0, '0, 12'd16, 1'b1));
        set_region(SHAPE_SQUARE, S_ZERO);
        send_entry(mk_entry(1'b1, '0, '0, 12'd17, 1'b1));

        for (phase = 0; phase < RANDOM_PHASES; phase++)
            run_random_phase(PHASE_ENTRIES);

        drain_results();
        board.finish_check();
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
design/rfms_pkg.sv
design/rfms_datapath.sv
design/rfms_ctrl.sv
design/region_first_match_scan_unit.sv
tb/tb_region_first_match_scan_unit.sv
